@@ src/acmp_pkg.sv @@
`default_nettype none
package acmp_pkg;

	localparam int unsigned TableDepth = 16;
	localparam int unsigned SlotW = 4;
	localparam int unsigned NsecPerMsec = 1000000;
	localparam logic [15:0] ConnectTimeoutReset = 16'd2000;
	localparam logic [15:0] DisconnectTimeoutReset = 16'd200;

	localparam logic [1:0] REQ_COMMAND = 2'd0;
	localparam logic [1:0] REQ_RESPONSE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [2:0] EV_FORWARD = 3'd0;
	localparam logic [2:0] EV_RELAY = 3'd1;
	localparam logic [2:0] EV_RETRANSMIT = 3'd2;
	localparam logic [2:0] EV_EXPIRED = 3'd3;
	localparam logic [2:0] EV_FULL = 3'd4;

	localparam logic [1:0] CFG_LOCAL_ID = 2'd0;
	localparam logic [1:0] CFG_CONNECT_TMO = 2'd1;
	localparam logic [1:0] CFG_DISCONNECT_TMO = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic is_disconnect;
		logic [63:0] target_guid;
		logic [15:0] seq_in;
		logic [63:0] now_ns;
	} req_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic disconnect_flag;
		logic [15:0] wire_sequence;
		logic [15:0] original_sequence;
		logic [3:0] slot_index;
		logic is_last;
	} res_t;

endpackage
`default_nettype wire

@@ src/acmp_front.sv @@
`default_nettype none
// Front: filters frames for other entities and unknown requests, queues the rest.
module acmp_front import acmp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_data,
	input wire logic [63:0] local_id,
	output logic q_valid,
	input wire logic q_pop,
	output req_t q_data
);
	req_t buf_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic take, keep;

	assign in_stall = (cnt_q == 2'd2);
	assign take = in_valid && !in_stall;
	assign keep = take && (in_data.req_type == REQ_TICK ||
		((in_data.req_type == REQ_COMMAND || in_data.req_type == REQ_RESPONSE) &&
		in_data.target_guid == local_id));
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (keep) buf_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (keep) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

@@ src/acmp_back.sv @@
`default_nettype none
// Back: slot-by-slot scan for command/response/tick, results via one output register.
module acmp_back import acmp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire req_t q_data,
	input wire logic [15:0] connect_tmo,
	input wire logic [15:0] disconnect_tmo,
	output logic out_valid,
	input wire logic out_stall,
	output res_t out_data
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_CALC = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	logic [TableDepth-1:0] valid_q;
	logic [TableDepth-1:0] disc_q;
	logic [TableDepth-1:0] retried_q;
	logic [15:0] aseq_q [TableDepth];
	logic [15:0] oseq_q [TableDepth];
	logic [63:0] sent_q [TableDepth];
	logic [15:0] next_seq_q;
	logic [SlotW-1:0] idx_q;
	logic [SlotW-1:0] si;
	logic [63:0] tmo_q;
	logic [63:0] elapsed_q;
	logic back_q;
	logic out_free;
	logic pend_q;
	res_t pend_d_q;
	logic last_slot;
	logic expired;
	logic push;

	assign si = idx_q;
	assign out_free = !out_valid || !out_stall;
	assign last_slot = (idx_q == SlotW'(TableDepth - 1));
	assign expired = !back_q && (elapsed_q >= tmo_q);
	// load the output register with the held result
	assign push = out_free && pend_q &&
		((state_q == ST_EMIT) || (state_q == ST_CALC && expired));

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && q_data.req_type == REQ_COMMAND && !valid_q[si]) begin
			disc_q[si] <= q_data.is_disconnect;
			retried_q[si] <= 1'b0;
			aseq_q[si] <= next_seq_q;
			oseq_q[si] <= q_data.seq_in;
			sent_q[si] <= q_data.now_ns;
		end
		if (state_q == ST_SCAN) begin
			tmo_q <= 64'(disc_q[si] ? disconnect_tmo : connect_tmo) * 64'(NsecPerMsec);
			back_q <= q_data.now_ns < sent_q[si];
			elapsed_q <= q_data.now_ns - sent_q[si];
		end
		if (state_q == ST_CALC && out_free && expired && !retried_q[si]) begin
			retried_q[si] <= 1'b1;
			sent_q[si] <= q_data.now_ns;
		end
		if (push) begin
			out_data <= (state_q == ST_EMIT) ? {pend_d_q[$bits(res_t)-1:1], 1'b1}
				: pend_d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			next_seq_q <= '0;
			idx_q <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (push) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SCAN;
						idx_q <= '0;
						pend_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					case (q_data.req_type)
						REQ_COMMAND: begin
							if (!valid_q[si]) begin
								valid_q[si] <= 1'b1;
								next_seq_q <= next_seq_q + 16'd1;
								pend_q <= 1'b1;
								pend_d_q <= '{EV_FORWARD, q_data.is_disconnect, next_seq_q,
									q_data.seq_in, si, 1'b1};
								state_q <= ST_EMIT;
							end else if (last_slot) begin
								pend_q <= 1'b1;
								pend_d_q <= '{EV_FULL, q_data.is_disconnect, 16'd0,
									q_data.seq_in, '0, 1'b1};
								state_q <= ST_EMIT;
							end else idx_q <= idx_q + 1'b1;
						end
						REQ_RESPONSE: begin
							if (valid_q[si] && aseq_q[si] == q_data.seq_in) begin
								valid_q[si] <= 1'b0;
								pend_q <= 1'b1;
								pend_d_q <= '{EV_RELAY, q_data.is_disconnect, oseq_q[si],
									oseq_q[si], si, 1'b1};
								state_q <= ST_EMIT;
							end else if (last_slot) state_q <= ST_EMIT;
							else idx_q <= idx_q + 1'b1;
						end
						default: begin
							if (valid_q[si]) state_q <= ST_CALC;
							else if (last_slot) state_q <= ST_EMIT;
							else idx_q <= idx_q + 1'b1;
						end
					endcase
				end
				ST_CALC: begin
					// hold a found expiry until the previous one is flushed
					if (expired) begin
						if (out_free) begin
							pend_q <= 1'b1;
							pend_d_q <= '{retried_q[si] ? EV_EXPIRED : EV_RETRANSMIT,
								disc_q[si], aseq_q[si], oseq_q[si], si, 1'b0};
							if (retried_q[si]) valid_q[si] <= 1'b0;
							if (last_slot) state_q <= ST_EMIT;
							else begin
								idx_q <= idx_q + 1'b1;
								state_q <= ST_SCAN;
							end
						end
					end else if (last_slot) state_q <= ST_EMIT;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pend_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign q_pop = (state_q == ST_EMIT) && out_free;
endmodule
`default_nettype wire

@@ src/acmp_pending_command_tracker.sv @@
`default_nettype none
// channel | valid    | stall     | payload
// req     | in_valid | in_stall  | in_data  (req_t)
// res     | out_valid| out_stall | out_data (res_t)
// cfg     | cfg_we   | -         | cfg_index, cfg_data
// A command or response scans up to 16 table slots; a tick passes SCAN and CALC
// for each valid slot and only SCAN for each free slot of the table.
// A two-entry queue sits between the front filter and the scanning back end.
// Reset clears slot valid bits, the sequence counter and registers to defaults.
// Output stall holds the scan at the next result found.
module acmp_pending_command_tracker import acmp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output res_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data
);
	logic [63:0] local_id_q;
	logic [15:0] ctmo_q, dtmo_q;
	logic q_valid, q_pop;
	req_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id_q <= '0;
			ctmo_q <= ConnectTimeoutReset;
			dtmo_q <= DisconnectTimeoutReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_ID: local_id_q <= cfg_data;
				CFG_CONNECT_TMO: ctmo_q <= cfg_data[15:0];
				CFG_DISCONNECT_TMO: dtmo_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	acmp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.local_id(local_id_q), .q_valid, .q_pop, .q_data
	);

	acmp_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.connect_tmo(ctmo_q), .disconnect_tmo(dtmo_q),
		.out_valid, .out_stall, .out_data
	);
endmodule
`default_nettype wire
